// ===== rtl/dwmd_pkg.sv =====
// ----------------------------------------------------------------------------
// dwmd_pkg
// Shared widths and constants of the distinct window marker detector.
// ----------------------------------------------------------------------------
package dwmd_pkg;

   localparam int SYM_W      = 8;                 // symbol width
   localparam int NUM_SYMS   = 1 << SYM_W;        // entries in the last-seen table
   localparam int MAX_WINDOW = 16;                // longest marker window
   localparam int RUN_W      = 5;                 // holds 0..MAX_WINDOW
   localparam int WIN_W      = 5;                 // window_len register width
   localparam int POS_W      = 32;                // position width
   localparam int IDX_W      = 9;                 // wrapping item index in the table

   localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);
   localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};

endpackage

// ===== rtl/dwmd_ram.sv =====
// ----------------------------------------------------------------------------
// dwmd_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module dwmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data <= mem_ff[rd_a_addr];
      rd_b_data <= mem_ff[rd_b_addr];
   end

endmodule

// ===== rtl/distinct_window_marker_detector_unit.sv =====
// ----------------------------------------------------------------------------
// distinct_window_marker_detector_unit
// Finds the first window of window_len pairwise distinct symbols in a stream.
// ----------------------------------------------------------------------------
// The unit takes one symbol per clock cycle unless the result output stalls,
// and reports the 1-based position of the symbol that completes the first run
// of csr window_len distinct symbols (0 reads as 1, above 16 reads as 16). A
// stream that ends (end_of_stream on its last symbol) without a marker gives one
// result with found low and position 0; a stream with a marker gives exactly
// one found result. A symbol is registered in the lookup stage, then its result
// enters the output register; a stalled output holds the lookup stage. The rate
// is set by a read-modify-write of a 256-entry table that holds, per symbol
// value, the wrapping index of its last occurrence; a write to the entry read
// in the same cycle is forwarded to that read. Per-entry valid bits in flip-flops
// are cleared by reset, so no clearing pass is needed, and a background scrubber
// walks the table (one entry per cycle) and retires entries too old to matter, so
// the wrapping index never aliases. Write csr_write_en only while the unit is idle.
// ----------------------------------------------------------------------------
module distinct_window_marker_detector_unit (
   input  logic                               clock,
   input  logic                               reset,
   // symbol input
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dwmd_pkg::SYM_W-1:0]         req_symbol,
   input  logic                               req_end_of_stream,
   // result output
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found,
   output logic [dwmd_pkg::POS_W-1:0]         rsp_position,
   // window length register
   input  logic                               csr_write_en,
   input  logic [dwmd_pkg::WIN_W-1:0]         csr_write_data
);

   localparam int SYM_W = dwmd_pkg::SYM_W;
   localparam int RUN_W = dwmd_pkg::RUN_W;
   localparam int IDX_W = dwmd_pkg::IDX_W;
   localparam int POS_W = dwmd_pkg::POS_W;

   // configuration
   logic [dwmd_pkg::WIN_W-1:0] win_ff;

   // lookup stage: one symbol waiting on its table read
   logic             s1_valid_ff;
   logic [SYM_W-1:0] s1_sym_ff;
   logic             s1_last_ff;

   // forwarding of a write that lands in the same cycle as the read
   logic             fwd_hit_ff, fwd_hit_in;
   logic [IDX_W-1:0] fwd_data_ff;

   // stream state
   logic [RUN_W-1:0] run_ff;
   logic [POS_W-1:0] count_ff;
   logic             seen_ff;
   logic [IDX_W-1:0] idx_ff;

   // last-seen table valid bits
   logic [dwmd_pkg::NUM_SYMS-1:0] vld_ff, vld_in;

   // scrubber
   logic [SYM_W-1:0] scrub_ptr_ff;
   logic [SYM_W-1:0] chk_addr_ff;
   logic             chk_skip_ff, chk_skip_in;
   logic             scrub_clr;

   // output register
   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [POS_W-1:0] rsp_position_ff;

   // table ports
   logic [SYM_W-1:0] rd_addr;
   logic [IDX_W-1:0] rd_a_data, rd_b_data;

   // lookup stage logic
   logic             req_xfer;
   logic             adv;
   logic [IDX_W-1:0] last_idx, gap, age;
   logic             seen_before, hit;
   logic [RUN_W-1:0] limit, run_new, eff_win;
   logic             mark, miss_end, has_rsp, out_free;
   logic [POS_W-1:0] count_next;

   assign req_xfer = req_valid && req_ready;

   // re-read the waiting symbol when nothing new arrives
   assign rd_addr = req_xfer ? req_symbol : s1_sym_ff;

   dwmd_ram #(
      .WIDTH(IDX_W),
      .DEPTH(dwmd_pkg::NUM_SYMS)
   ) u_last_seen (
      .clock     (clock),
      .wr_en     (adv),
      .wr_addr   (s1_sym_ff),
      .wr_data   (idx_ff),
      .rd_a_addr (rd_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (scrub_ptr_ff),
      .rd_b_data (rd_b_data)
   );

   always_comb begin
      last_idx    = fwd_hit_ff ? fwd_data_ff : rd_a_data;
      seen_before = vld_ff[s1_sym_ff] || fwd_hit_ff;
      gap         = idx_ff - last_idx;
      limit       = (run_ff > RUN_W'(dwmd_pkg::MAX_WINDOW - 1)) ?
                    RUN_W'(dwmd_pkg::MAX_WINDOW - 1) : run_ff;
      // a repeat counts only if it lies inside the current run
      hit         = seen_before && ({{(IDX_W-RUN_W){1'b0}}, limit} >= gap);
      run_new     = hit ? gap[RUN_W-1:0] : limit + RUN_W'(1);

      if (win_ff == '0) begin
         eff_win = RUN_W'(1);
      end else if (win_ff > dwmd_pkg::WIN_W'(dwmd_pkg::MAX_WINDOW)) begin
         eff_win = RUN_W'(dwmd_pkg::MAX_WINDOW);
      end else begin
         eff_win = RUN_W'(win_ff);
      end

      mark       = !seen_ff && (run_new >= eff_win);
      miss_end   = !seen_ff && !mark && s1_last_ff;
      has_rsp    = mark || miss_end;
      out_free   = !rsp_valid_ff || rsp_ready;
      // a symbol without a result never waits on the output
      adv        = s1_valid_ff && (!has_rsp || out_free);
      count_next = (count_ff == dwmd_pkg::POS_MAX) ? count_ff : count_ff + POS_W'(1);
   end

   assign req_ready  = !s1_valid_ff || adv;
   assign fwd_hit_in = adv && (rd_addr == s1_sym_ff);

   // scrub: retire entries whose distance to any later symbol exceeds a window
   assign age         = idx_ff - rd_b_data;
   assign chk_skip_in = adv && (s1_sym_ff == scrub_ptr_ff);
   assign scrub_clr   = !chk_skip_ff && !(adv && (s1_sym_ff == chk_addr_ff)) &&
                        (age > IDX_W'(dwmd_pkg::MAX_WINDOW));

   always_comb begin
      vld_in = vld_ff;
      if (scrub_clr) begin
         vld_in[chk_addr_ff] = 1'b0;
      end
      if (adv) begin
         vld_in[s1_sym_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= dwmd_pkg::WIN_RESET;
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         run_ff       <= '0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         idx_ff       <= '0;
         vld_ff       <= '0;
         scrub_ptr_ff <= '0;
         chk_skip_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            win_ff <= csr_write_data;
         end

         // advance the lookup stage
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
         end else if (adv) begin
            s1_valid_ff <= 1'b0;
         end
         fwd_hit_ff <= fwd_hit_in;

         // update the stream state once per symbol
         if (adv) begin
            idx_ff <= idx_ff + IDX_W'(1);
            if (s1_last_ff) begin
               run_ff   <= '0;
               count_ff <= '0;
               seen_ff  <= 1'b0;
            end else begin
               count_ff <= count_next;
               if (!seen_ff) begin
                  run_ff <= run_new;
               end
               if (mark) begin
                  seen_ff <= 1'b1;
               end
            end
         end

         vld_ff       <= vld_in;
         scrub_ptr_ff <= scrub_ptr_ff + SYM_W'(1);
         chk_skip_ff  <= chk_skip_in;

         // hold a result until its transfer
         if (adv && has_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_sym_ff  <= req_symbol;
         s1_last_ff <= req_end_of_stream;
      end
      fwd_data_ff <= idx_ff;
      chk_addr_ff <= scrub_ptr_ff;
      if (adv && has_rsp) begin
         rsp_found_ff    <= mark;
         rsp_position_ff <= mark ? count_next : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule

// ===== rtl/dwmd_checker.sv =====
// ----------------------------------------------------------------------------
// dwmd_checker
// Port-level checks of the distinct window marker detector, bound to the top.
// ----------------------------------------------------------------------------
module dwmd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_found,
   input logic [dwmd_pkg::POS_W-1:0] rsp_position
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_position))
      else $error("result changed while stalled");

   // a not-found result carries position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("not-found result with nonzero position");

   // a found result points at a real symbol
   a_hit_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_position != '0)
      else $error("found result with position zero");

   // a result never appears without a symbol transfer or a valid symbol request before it
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2) || $past(req_valid, 3))
      else $error("result without a preceding symbol");

endmodule

bind distinct_window_marker_detector_unit dwmd_checker u_dwmd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_found    (rsp_found),
   .rsp_position (rsp_position)
);
